FILE: rtl/core/assert_macros.svh
// assertion macros used by psr_datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: rtl/core/psr_pkg.sv
// types, codes and widths shared by the resampler modules
package psr_pkg;
	localparam int XW  = 16;
	localparam int IW  = 15;
	localparam int SSW = 15;
	localparam int CPW = 16;
	localparam int DW  = 17;
	localparam int QW  = 34;
	localparam int RW  = 17;
	localparam int SRW = 8;

	localparam logic [1:0] FN_POINT = 2'd0;
	localparam logic [1:0] FN_BREAK = 2'd1;
	localparam logic [1:0] FN_END   = 2'd2;

	localparam logic [4:0] OP_NONE     = 5'd0;
	localparam logic [4:0] OP_LEAD     = 5'd1;
	localparam logic [4:0] OP_DIFF     = 5'd2;
	localparam logic [4:0] OP_SQX      = 5'd3;
	localparam logic [4:0] OP_SQY      = 5'd4;
	localparam logic [4:0] OP_SQRT     = 5'd5;
	localparam logic [4:0] OP_DSLOAD   = 5'd6;
	localparam logic [4:0] OP_MULX     = 5'd7;
	localparam logic [4:0] OP_DIVX     = 5'd8;
	localparam logic [4:0] OP_IXLOAD   = 5'd9;
	localparam logic [4:0] OP_MULY     = 5'd10;
	localparam logic [4:0] OP_DIVY     = 5'd11;
	localparam logic [4:0] OP_IYLOAD   = 5'd12;
	localparam logic [4:0] OP_APPEND   = 5'd13;
	localparam logic [4:0] OP_EMIT_END = 5'd14;
	localparam logic [4:0] OP_REPLACE  = 5'd15;
	localparam logic [4:0] OP_ROOT     = 5'd16;
	localparam logic [4:0] OP_ROOTLOAD = 5'd17;

	localparam logic [1:0] SEL_CLOSE  = 2'd0;
	localparam logic [1:0] SEL_BRK    = 2'd1;
	localparam logic [1:0] SEL_PT     = 2'd2;
	localparam logic [1:0] SEL_INTERP = 2'd3;

	localparam logic ADDR_STEP = 1'b0;
	localparam logic ADDR_CAP  = 1'b1;

	typedef struct packed {
		logic [4:0] op;
		logic [1:0] sel;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       have_lead;
		logic       held_brk;
		logic       at_limit;
		logic       next_brk;
		logic       far;
		logic       near_app;
		logic       loop_go;
		logic       sqrt_done;
		logic       div_done;
		logic       out_free;
		logic       root_pend;
	} stat_t;
endpackage

FILE: rtl/core/pen_stroke_resampler.sv
// top level of the pen stroke resampler
// one item at a time; in_ready is low from acceptance until its results are queued
// point or break: appended once the output register is free; near point: squared distance, then appended or not
// far point: a square root, then per interpolated point two 17-step divides (x and y)
// a write of step_squared recomputes the root, with no item taken meanwhile
// reset is asynchronous: step 64 (root 8), capacity 4096, empty trajectory
module pen_stroke_resampler #(
	parameter int MAX_INTERP   = 62,
	parameter int LIMIT_MARGIN = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    func,
	input  logic signed [psr_pkg::XW-1:0] x,
	input  logic signed [psr_pkg::XW-1:0] y,
	input  logic                          next_is_break,
	input  logic [psr_pkg::IW-1:0]        source_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [psr_pkg::XW-1:0] out_x,
	output logic signed [psr_pkg::XW-1:0] out_y,
	output logic                          out_break,
	output logic [psr_pkg::IW-1:0]        out_index,
	output logic                          last
);
	psr_pkg::cmd_t  cmd;
	psr_pkg::stat_t st;

	assign pready = 1'b1;

	psr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	psr_datapath #(
		.MAX_INTERP   (MAX_INTERP),
		.LIMIT_MARGIN (LIMIT_MARGIN)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.x             (x),
		.y             (y),
		.next_is_break (next_is_break),
		.source_index  (source_index),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_x         (out_x),
		.out_y         (out_y),
		.out_break     (out_break),
		.out_index     (out_index),
		.last          (last)
	);
endmodule

FILE: rtl/core/psr_isqrt.sv
// iterative integer square root, two operand bits per cycle while busy
module psr_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [psr_pkg::QW-1:0]     operand,
	output logic                       busy,
	output logic                       done,
	output logic [psr_pkg::RW-1:0]     root
);
	localparam int REMW = psr_pkg::RW + 4;
	localparam int CNTW = $clog2(psr_pkg::RW + 1);

	logic [psr_pkg::QW-1:0] val_q;
	logic [REMW-1:0]        rem_q;
	logic [psr_pkg::RW-1:0] root_q;
	logic [CNTW-1:0]        cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [REMW-1:0]        rem_sh;
	logic [REMW-1:0]        trial;
	logic                   ge;

	assign rem_sh = {rem_q[REMW-3:0], val_q[psr_pkg::QW-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(psr_pkg::RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[psr_pkg::QW-3:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[psr_pkg::RW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;
endmodule

FILE: rtl/core/psr_div.sv
// restoring divider, one quotient bit per cycle while busy
module psr_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [psr_pkg::QW-1:0]     dividend,
	input  logic [psr_pkg::RW-1:0]     divisor,
	output logic                       busy,
	output logic                       done,
	output logic [psr_pkg::RW-1:0]     quot
);
	localparam int CNTW = $clog2(psr_pkg::RW + 1);

	logic [psr_pkg::RW-1:0] rem_q;
	logic [psr_pkg::RW-1:0] dq_q;
	logic [psr_pkg::RW-1:0] dv_q;
	logic [CNTW-1:0]        cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [psr_pkg::RW:0]   sh;
	logic                   ge;

	assign sh = {rem_q, dq_q[psr_pkg::RW-1]};
	assign ge = sh >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(psr_pkg::RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[psr_pkg::QW-1 -: psr_pkg::RW];
			dq_q  <= dividend[psr_pkg::RW-1:0];
			dv_q  <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? psr_pkg::RW'(sh - {1'b0, dv_q}) : sh[psr_pkg::RW-1:0];
			dq_q  <= {dq_q[psr_pkg::RW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = dq_q;
endmodule

FILE: rtl/core/psr_ctrl.sv
// sequencer for the resampler datapath
module psr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  psr_pkg::stat_t  st,
	output psr_pkg::cmd_t   cmd
);
	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_ROOTW  = 5'd1;
	localparam logic [4:0] S_DECIDE = 5'd2;
	localparam logic [4:0] S_CLOSE  = 5'd3;
	localparam logic [4:0] S_END    = 5'd4;
	localparam logic [4:0] S_ABRK   = 5'd5;
	localparam logic [4:0] S_APT    = 5'd6;
	localparam logic [4:0] S_SQX    = 5'd7;
	localparam logic [4:0] S_SQY    = 5'd8;
	localparam logic [4:0] S_CMP    = 5'd9;
	localparam logic [4:0] S_SQW    = 5'd10;
	localparam logic [4:0] S_LOOP   = 5'd11;
	localparam logic [4:0] S_DX     = 5'd12;
	localparam logic [4:0] S_DXW    = 5'd13;
	localparam logic [4:0] S_MY     = 5'd14;
	localparam logic [4:0] S_DY     = 5'd15;
	localparam logic [4:0] S_DYW    = 5'd16;
	localparam logic [4:0] S_AINT   = 5'd17;

	logic [4:0] state_q;
	logic [4:0] state_d;

	assign in_ready = (state_q == S_IDLE) && !st.root_pend;

	always_comb begin
		state_d  = state_q;
		cmd.op   = psr_pkg::OP_NONE;
		cmd.sel  = psr_pkg::SEL_PT;
		cmd.last = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (st.root_pend) begin
					cmd.op  = psr_pkg::OP_ROOT;
					state_d = S_ROOTW;
				end else if (in_valid) begin
					state_d = S_DECIDE;
				end
			end
			S_ROOTW: begin
				if (st.sqrt_done) begin
					cmd.op  = psr_pkg::OP_ROOTLOAD;
					state_d = S_IDLE;
				end
			end
			S_DECIDE: begin
				state_d = S_IDLE;
				if (st.func == psr_pkg::FN_END) begin
					state_d = (st.have_lead && !st.held_brk) ? S_CLOSE : S_END;
				end else if (st.func == psr_pkg::FN_POINT || st.func == psr_pkg::FN_BREAK) begin
					if (!st.have_lead) begin
						cmd.op = psr_pkg::OP_LEAD;
					end else if (!st.at_limit) begin
						if (st.func == psr_pkg::FN_BREAK) begin
							state_d = S_ABRK;
						end else if (st.held_brk) begin
							state_d = S_APT;
						end else begin
							cmd.op  = psr_pkg::OP_DIFF;
							state_d = S_SQX;
						end
					end
				end
			end
			S_CLOSE: begin
				if (st.out_free) begin
					cmd.op  = psr_pkg::OP_APPEND;
					cmd.sel = psr_pkg::SEL_CLOSE;
					state_d = S_END;
				end
			end
			S_END: begin
				if (st.out_free) begin
					cmd.op   = psr_pkg::OP_EMIT_END;
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_ABRK: begin
				if (st.out_free) begin
					cmd.op   = psr_pkg::OP_APPEND;
					cmd.sel  = psr_pkg::SEL_BRK;
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_APT: begin
				if (st.out_free) begin
					cmd.op   = psr_pkg::OP_APPEND;
					cmd.sel  = psr_pkg::SEL_PT;
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_SQX: begin
				cmd.op  = psr_pkg::OP_SQX;
				state_d = S_SQY;
			end
			S_SQY: begin
				cmd.op  = psr_pkg::OP_SQY;
				state_d = S_CMP;
			end
			S_CMP: begin
				if (st.far) begin
					cmd.op  = psr_pkg::OP_SQRT;
					state_d = S_SQW;
				end else if (st.next_brk && st.near_app) begin
					state_d = S_APT;
				end else begin
					if (st.next_brk) cmd.op = psr_pkg::OP_REPLACE;
					state_d = S_IDLE;
				end
			end
			S_SQW: begin
				if (st.sqrt_done) begin
					cmd.op  = psr_pkg::OP_DSLOAD;
					state_d = S_LOOP;
				end
			end
			S_LOOP: begin
				if (st.loop_go) begin
					cmd.op  = psr_pkg::OP_MULX;
					state_d = S_DX;
				end else begin
					state_d = S_APT;
				end
			end
			S_DX: begin
				cmd.op  = psr_pkg::OP_DIVX;
				state_d = S_DXW;
			end
			S_DXW: begin
				if (st.div_done) begin
					cmd.op  = psr_pkg::OP_IXLOAD;
					state_d = S_MY;
				end
			end
			S_MY: begin
				cmd.op  = psr_pkg::OP_MULY;
				state_d = S_DY;
			end
			S_DY: begin
				cmd.op  = psr_pkg::OP_DIVY;
				state_d = S_DYW;
			end
			S_DYW: begin
				if (st.div_done) begin
					cmd.op  = psr_pkg::OP_IYLOAD;
					state_d = S_AINT;
				end
			end
			S_AINT: begin
				if (st.out_free) begin
					cmd.op  = psr_pkg::OP_APPEND;
					cmd.sel = psr_pkg::SEL_INTERP;
					state_d = S_LOOP;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

FILE: rtl/core/psr_datapath.sv
// resampler registers, arithmetic, held item and output register
`include "assert_macros.svh"
module psr_datapath #(
	parameter int MAX_INTERP   = 62,
	parameter int LIMIT_MARGIN = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  psr_pkg::cmd_t                 cmd,
	output psr_pkg::stat_t                st,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [1:0]                    func,
	input  logic signed [psr_pkg::XW-1:0] x,
	input  logic signed [psr_pkg::XW-1:0] y,
	input  logic                          next_is_break,
	input  logic [psr_pkg::IW-1:0]        source_index,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [psr_pkg::XW-1:0] out_x,
	output logic signed [psr_pkg::XW-1:0] out_y,
	output logic                          out_break,
	output logic [psr_pkg::IW-1:0]        out_index,
	output logic                          last
);
	localparam int CW = $clog2(MAX_INTERP + 1);
	localparam int XW = psr_pkg::XW;
	localparam int IW = psr_pkg::IW;
	localparam int DW = psr_pkg::DW;
	localparam int QW = psr_pkg::QW;
	localparam int RW = psr_pkg::RW;
	localparam int PW = DW + RW + 1;

	logic [psr_pkg::SSW-1:0] step_sq_q;
	logic [psr_pkg::CPW-1:0] cap_q;
	logic [psr_pkg::SRW-1:0] root_q;
	logic                    root_pend_q;
	logic [1:0]              func_q;
	logic signed [XW-1:0]    x_q;
	logic signed [XW-1:0]    y_q;
	logic                    nb_q;
	logic [IW-1:0]           src_q;
	logic signed [XW-1:0]    held_x_q;
	logic signed [XW-1:0]    held_y_q;
	logic                    held_brk_q;
	logic [IW-1:0]           held_idx_q;
	logic                    have_lead_q;
	logic [psr_pkg::CPW-1:0] count_q;
	logic [IW-1:0]           last_src_q;
	logic signed [DW-1:0]    dx_q;
	logic signed [DW-1:0]    dy_q;
	logic [QW-1:0]           acc_q;
	logic signed [XW-1:0]    rx_q;
	logic signed [XW-1:0]    ry_q;
	logic [RW-1:0]           ds_q;
	logic [RW:0]             h_q;
	logic [CW-1:0]           cnt_q;
	logic signed [PW-1:0]    prod_q;
	logic                    neg_q;
	logic [XW-1:0]           ix_q;
	logic [XW-1:0]           iy_q;
	logic                    out_valid_q;
	logic cfg_wr;
	logic [psr_pkg::CPW-1:0] limit;
	logic signed [2*DW-1:0]  sq;
	logic signed [PW-1:0]    prod_d;
	logic [PW-1:0]           mag;
	logic [XW-1:0]           qoff;
	logic                    sq_start;
	logic [QW-1:0]           sq_opnd;
	logic                    sq_busy;
	logic                    sq_done;
	logic [RW-1:0]           sq_root;
	logic                    dv_start;
	logic                    dv_busy;
	logic                    dv_done;
	logic [RW-1:0]           dv_quot;
	logic [XW-1:0]           nx;
	logic [XW-1:0]           ny;
	logic                    nbrk;
	logic [IW-1:0]           nidx;
	logic                    in_acc;
	logic                    is_app;

	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == psr_pkg::ADDR_CAP) ? {16'd0, cap_q} : {17'd0, step_sq_q};
	assign in_acc = in_valid && in_ready;
	assign is_app = (cmd.op == psr_pkg::OP_APPEND) || (cmd.op == psr_pkg::OP_EMIT_END);

	assign limit = (cap_q > psr_pkg::CPW'(LIMIT_MARGIN)) ?
		cap_q - psr_pkg::CPW'(LIMIT_MARGIN) : '0;

	assign sq     = (cmd.op == psr_pkg::OP_SQX) ? dx_q * dx_q : dy_q * dy_q;
	assign prod_d = ((cmd.op == psr_pkg::OP_MULX) ? dx_q : dy_q) *
		$signed({1'b0, h_q[RW-1:0]});
	assign mag    = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
	assign qoff   = neg_q ? XW'(-dv_quot[XW-1:0]) : dv_quot[XW-1:0];

	assign sq_start = (cmd.op == psr_pkg::OP_SQRT) || (cmd.op == psr_pkg::OP_ROOT);
	assign sq_opnd  = (cmd.op == psr_pkg::OP_ROOT) ? QW'(step_sq_q) : acc_q;
	assign dv_start = (cmd.op == psr_pkg::OP_DIVX) || (cmd.op == psr_pkg::OP_DIVY);

	psr_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.operand (sq_opnd),
		.busy    (sq_busy),
		.done    (sq_done),
		.root    (sq_root)
	);

	psr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (mag[QW-1:0]),
		.divisor  (ds_q),
		.busy     (dv_busy),
		.done     (dv_done),
		.quot     (dv_quot)
	);

	always_comb begin
		nx   = x_q;
		ny   = y_q;
		nbrk = 1'b0;
		nidx = src_q;
		case (cmd.sel)
			psr_pkg::SEL_CLOSE: begin
				nx   = '0;
				ny   = '0;
				nbrk = 1'b1;
				nidx = last_src_q;
			end
			psr_pkg::SEL_BRK: begin
				ny   = '0;
				nbrk = 1'b1;
			end
			psr_pkg::SEL_INTERP: begin
				nx   = ix_q;
				ny   = iy_q;
				nidx = (h_q < {2'b00, ds_q[RW-1:1]}) ? held_idx_q : src_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_sq_q   <= psr_pkg::SSW'(64);
			cap_q       <= psr_pkg::CPW'(4096);
			root_q      <= psr_pkg::SRW'(8);
			root_pend_q <= 1'b0;
			held_x_q    <= '0;
			held_y_q    <= '0;
			held_brk_q  <= 1'b1;
			held_idx_q  <= '0;
			have_lead_q <= 1'b0;
			count_q     <= '0;
			last_src_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == psr_pkg::OP_ROOT) root_pend_q <= 1'b0;
			if (cfg_wr) begin
				if (paddr[2] == psr_pkg::ADDR_STEP) begin
					step_sq_q   <= pwdata[psr_pkg::SSW-1:0];
					root_pend_q <= 1'b1;
				end else begin
					cap_q <= pwdata[psr_pkg::CPW-1:0];
				end
			end
			if (cmd.op == psr_pkg::OP_ROOTLOAD) begin
				root_q <= (sq_root <= RW'(1)) ? psr_pkg::SRW'(2) : sq_root[psr_pkg::SRW-1:0];
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (is_app) out_valid_q <= 1'b1;
			case (cmd.op)
				psr_pkg::OP_LEAD: begin
					have_lead_q <= 1'b1;
					held_x_q    <= '0;
					held_y_q    <= '0;
					held_brk_q  <= 1'b1;
					held_idx_q  <= src_q;
					last_src_q  <= src_q;
				end
				psr_pkg::OP_DIFF: last_src_q <= src_q;
				psr_pkg::OP_REPLACE: begin
					held_x_q   <= x_q;
					held_y_q   <= y_q;
					held_idx_q <= src_q;
				end
				psr_pkg::OP_APPEND: begin
					held_x_q   <= nx;
					held_y_q   <= ny;
					held_brk_q <= nbrk;
					held_idx_q <= nidx;
					if (count_q != '1) count_q <= count_q + 1'b1;
					if (cmd.sel == psr_pkg::SEL_BRK || cmd.sel == psr_pkg::SEL_PT) begin
						last_src_q <= src_q;
					end
				end
				psr_pkg::OP_EMIT_END: begin
					held_x_q    <= '0;
					held_y_q    <= '0;
					held_brk_q  <= 1'b1;
					held_idx_q  <= '0;
					have_lead_q <= 1'b0;
					count_q     <= '0;
					last_src_q  <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q <= func;
			x_q    <= x;
			y_q    <= y;
			nb_q   <= next_is_break;
			src_q  <= source_index;
		end
		if (is_app) begin
			out_x     <= (cmd.op == psr_pkg::OP_EMIT_END && held_brk_q) ? '0 : held_x_q;
			out_y     <= held_y_q;
			out_break <= held_brk_q;
			out_index <= held_idx_q;
			last      <= cmd.last;
		end
		case (cmd.op)
			psr_pkg::OP_DIFF: begin
				dx_q <= DW'(x_q) - DW'(held_x_q);
				dy_q <= DW'(y_q) - DW'(held_y_q);
			end
			psr_pkg::OP_SQX: acc_q <= QW'(sq);
			psr_pkg::OP_SQY: acc_q <= acc_q + QW'(sq);
			psr_pkg::OP_SQRT: begin
				rx_q <= held_x_q;
				ry_q <= held_y_q;
			end
			psr_pkg::OP_DSLOAD: begin
				ds_q  <= sq_root;
				h_q   <= (RW+1)'(root_q);
				cnt_q <= '0;
			end
			psr_pkg::OP_MULX, psr_pkg::OP_MULY: prod_q <= prod_d;
			psr_pkg::OP_DIVX, psr_pkg::OP_DIVY: neg_q <= prod_q[PW-1];
			psr_pkg::OP_IXLOAD: ix_q <= rx_q + qoff;
			psr_pkg::OP_IYLOAD: iy_q <= ry_q + qoff;
			psr_pkg::OP_APPEND: begin
				if (cmd.sel == psr_pkg::SEL_INTERP) begin
					h_q   <= h_q + (RW+1)'(root_q);
					cnt_q <= cnt_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

	assign st.func      = func_q;
	assign st.have_lead = have_lead_q;
	assign st.held_brk  = held_brk_q;
	assign st.at_limit  = count_q >= limit;
	assign st.next_brk  = nb_q;
	assign st.far       = QW'(step_sq_q) < acc_q;
	assign st.near_app  = acc_q > QW'(step_sq_q[psr_pkg::SSW-1:2]);
	assign st.loop_go   = (h_q < {1'b0, ds_q}) && !(count_q >= limit) &&
		(cnt_q < CW'(MAX_INTERP));
	assign st.sqrt_done = sq_done;
	assign st.div_done  = dv_done;
	assign st.out_free  = !out_valid_q || out_ready;
	assign st.root_pend = root_pend_q;

	`ASSERT_IMPLIES(a_app_free, clk, arst_n, is_app, !out_valid_q || out_ready)
	`ASSERT_IMPLIES(a_acc_quiet, clk, arst_n, in_acc, !sq_busy && !dv_busy && !root_pend_q)
	`ASSERT_NEXT(a_root_pend, clk, arst_n, cfg_wr && paddr[2] == psr_pkg::ADDR_STEP, root_pend_q)
endmodule

FILE: tb/sv/pen_stroke_resampler_tb.sv
// testbench for pen_stroke_resampler: directed and random strokes checked against a built-in predictor
`timescale 1ns / 1ps

typedef struct {
	logic signed [15:0] px;
	logic signed [15:0] py;
	bit                 brk;
	logic [14:0]        idx;
	bit                 lst;
} resampled_pt_t;

typedef struct {
	logic [1:0]         f;
	logic signed [15:0] px;
	logic signed [15:0] py;
	bit                 nb;
	logic [14:0]        src;
} pen_req_t;

function automatic longint unsigned floor_sqrt(longint unsigned v);
	longint unsigned root;
	longint unsigned bitv;
	root = 0;
	bitv = 64'd1 << 62;
	while (bitv > v) bitv >>= 2;
	while (bitv != 0) begin
		if (v >= root + bitv) begin
			v -= root + bitv;
			root = (root >> 1) + bitv;
		end else begin
			root >>= 1;
		end
		bitv >>= 2;
	end
	return root;
endfunction

class resample_scoreboard;
	resampled_pt_t points_due[$];
	int errors;
	int unsigned step_sq, cap, cnt, root;
	int hx, hy;
	bit hbrk, lead;
	logic [14:0] hidx, lastsrc;

	function new();
		errors = 0;
		set_reg(0, 64);
		set_reg(1, 4096);
		clear_track();
	endfunction

	function void clear_track();
		hx = 0; hy = 0; hbrk = 1; hidx = 0; lead = 0; cnt = 0; lastsrc = 0;
	endfunction

	function void set_reg(int sel, int unsigned v);
		longint unsigned r;
		if (sel == 0) begin
			step_sq = v & 16'h7FFF;
			r = floor_sqrt(step_sq);
			root = (r <= 1) ? 2 : 32'(r);
		end else begin
			cap = v & 16'hFFFF;
		end
	endfunction

	function void emit_held();
		resampled_pt_t p;
		p.px = hx[15:0]; p.py = hy[15:0]; p.brk = hbrk; p.idx = hidx; p.lst = 0;
		points_due.push_back(p);
	endfunction

	function void push_pt(int nx, int ny, bit nbrk, logic [14:0] nidx);
		emit_held();
		hx = $signed(nx[15:0]); hy = $signed(ny[15:0]); hbrk = nbrk; hidx = nidx;
		if (cnt < 65535) cnt++;
	endfunction

	function void note(pen_req_t r);
		int n0;
		int unsigned lim;
		longint dx, dy, ds, h;
		longint unsigned dsl;
		int c, ix, iy;
		n0 = points_due.size();
		lim = (cap > 7) ? cap - 7 : 0;
		if (r.f == 2'd3) return;
		if (r.f == psr_pkg::FN_END) begin
			if (lead && !hbrk) push_pt(0, 0, 1, lastsrc);
			if (hbrk) hx = 0;
			emit_held();
			points_due[points_due.size()-1].lst = 1;
			clear_track();
			return;
		end
		if (!lead) begin
			lead = 1; hx = 0; hy = 0; hbrk = 1; hidx = r.src; lastsrc = r.src;
			return;
		end
		if (cnt >= lim) return;
		lastsrc = r.src;
		if (r.f == psr_pkg::FN_BREAK) begin
			push_pt(r.px, 0, 1, r.src);
		end else if (hbrk) begin
			push_pt(r.px, r.py, 0, r.src);
		end else begin
			dx = longint'(r.px) - hx;
			dy = longint'(r.py) - hy;
			dsl = dx * dx + dy * dy;
			if (step_sq < dsl) begin
				ds = floor_sqrt(dsl);
				h = root;
				c = 0;
				ix = hx; iy = hy;
				while (h < ds && cnt < lim && c < 62) begin
					push_pt(32'(ix + (dx * h) / ds), 32'(iy + (dy * h) / ds), 0,
						(h < (ds >>> 1)) ? hidx : r.src);
					h += root;
					c++;
				end
				push_pt(r.px, r.py, 0, r.src);
			end else if (r.nb) begin
				if (dsl > (step_sq >> 2)) begin
					push_pt(r.px, r.py, 0, r.src);
				end else begin
					hx = r.px; hy = r.py; hidx = r.src;
				end
			end
		end
		if (points_due.size() > n0) points_due[points_due.size()-1].lst = 1;
	endfunction

	function void check(resampled_pt_t a);
		resampled_pt_t e;
		if (points_due.size() == 0) begin
			$display("%0t: unexpected result x=%0d y=%0d brk=%0b idx=%0d last=%0b",
				$time, a.px, a.py, a.brk, a.idx, a.lst);
			errors++;
			return;
		end
		e = points_due.pop_front();
		if (e.px !== a.px || e.py !== a.py || e.brk !== a.brk || e.idx !== a.idx ||
			e.lst !== a.lst) begin
			$display("%0t: mismatch expected x=%0d y=%0d brk=%0b idx=%0d last=%0b",
				$time, e.px, e.py, e.brk, e.idx, e.lst);
			$display("%0t:          actual   x=%0d y=%0d brk=%0b idx=%0d last=%0b",
				$time, a.px, a.py, a.brk, a.idx, a.lst);
			errors++;
		end
	endfunction
endclass

module pen_stroke_resampler_tb;
	localparam logic [1:0] FN_IGNORED = 2'd3;
	localparam logic [2:0] A_STEP = 3'd0;
	localparam logic [2:0] A_CAP  = 3'd4;

	logic clk = 0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready;
	logic [1:0] func;
	logic signed [15:0] x, y;
	logic next_is_break;
	logic [14:0] source_index;
	logic out_valid, out_ready;
	logic signed [15:0] out_x, out_y;
	logic out_break;
	logic [14:0] out_index;
	logic last;

	resample_scoreboard sb = new();
	pen_req_t plan[$];
	bit calm = 0;
	int hold_left = 0;
	int walk_x, walk_y;
	logic [14:0] src_ctr = 0;

	pen_stroke_resampler uut (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		pen_req_t r;
		resampled_pt_t a;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				r.f = func; r.px = x; r.py = y; r.nb = next_is_break; r.src = source_index;
				sb.note(r);
			end
			if (out_valid && out_ready) begin
				a.px = out_x; a.py = out_y; a.brk = out_break; a.idx = out_index; a.lst = last;
				sb.check(a);
			end
		end
	end

	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 0;
				hold_left--;
			end else if (calm) begin
				out_ready <= 1;
			end else begin
				out_ready <= ($urandom_range(99) >= 17);
			end
		end
	end

	initial begin
		#200ms;
		$display("FAIL pen_stroke_resampler");
		$finish;
	end

	task automatic write_reg(input logic [2:0] a, input logic [31:0] d);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		sb.set_reg(a == A_STEP ? 0 : 1, d);
	endtask

	task automatic wait_idle();
		while (sb.points_due.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic send(input pen_req_t it);
		if (!calm)
			while ($urandom_range(99) < 17) begin
				@(negedge clk);
				in_valid <= 0;
			end
		@(negedge clk);
		in_valid <= 1; func <= it.f; x <= it.px; y <= it.py;
		next_is_break <= it.nb; source_index <= it.src;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic add(input logic [1:0] f, input int px, input int py);
		pen_req_t r;
		r.f = f; r.px = px[15:0]; r.py = py[15:0]; r.nb = 0;
		if ($urandom_range(99) < 5) src_ctr = 15'($urandom);
		else src_ctr = 15'(src_ctr + $urandom_range(1, 3));
		r.src = src_ctr;
		plan.push_back(r);
	endtask

	task automatic send_plan(input bit noisy);
		pen_req_t r;
		for (int i = 0; i < plan.size(); i++) begin
			r = plan[i];
			r.nb = (i + 1 < plan.size()) && (plan[i+1].f == psr_pkg::FN_BREAK);
			if (noisy && $urandom_range(99) < 5) r.nb = ~r.nb;
			send(r);
		end
		plan.delete();
		@(negedge clk);
		in_valid <= 0;
	endtask

	task automatic build_strokes(input int n);
		int made, k, d;
		made = 0;
		d = 3 * sb.root;
		while (made < n) begin
			add($urandom_range(1) ? psr_pkg::FN_BREAK : psr_pkg::FN_POINT, $urandom, $urandom);
			made++;
			k = $urandom_range(3, 15);
			for (int j = 0; j < k; j++) begin
				if ($urandom_range(99) < 3) add(FN_IGNORED, $urandom, $urandom);
				if ($urandom_range(99) < 12) begin
					add(psr_pkg::FN_BREAK, $urandom, $urandom);
				end else begin
					if ($urandom_range(99) < 4) begin
						walk_x = $signed(16'($urandom));
						walk_y = $signed(16'($urandom));
					end else begin
						walk_x += $urandom_range(0, 2 * d) - d;
						walk_y += $urandom_range(0, 2 * d) - d;
					end
					walk_x = $signed(walk_x[15:0]);
					walk_y = $signed(walk_y[15:0]);
					add(psr_pkg::FN_POINT, walk_x, walk_y);
				end
				made++;
			end
			if ($urandom_range(99) < 70) begin
				add(psr_pkg::FN_END, $urandom, $urandom);
				made++;
			end
		end
		add(psr_pkg::FN_END, 0, 0);
	endtask

	task automatic run_phase(input int unsigned st, input int unsigned cp, input int n);
		wait_idle();
		write_reg(A_STEP, st);
		write_reg(A_CAP, cp);
		walk_x = $signed(16'($urandom));
		walk_y = $signed(16'($urandom));
		build_strokes(n);
		send_plan(1);
	endtask

	initial begin
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; func = 0; x = 0; y = 0; next_is_break = 0; source_index = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed: reset settings
		add(psr_pkg::FN_POINT, 5, 5);
		add(psr_pkg::FN_POINT, 0, 0);
		add(psr_pkg::FN_POINT, 3, 3);
		add(psr_pkg::FN_POINT, 4, 4);
		add(psr_pkg::FN_BREAK, 77, 9);
		add(psr_pkg::FN_POINT, 10, 10);
		add(psr_pkg::FN_POINT, 11, 10);
		add(psr_pkg::FN_BREAK, -5, 3);
		add(psr_pkg::FN_POINT, 11, 10);
		add(psr_pkg::FN_POINT, 40, 30);
		add(psr_pkg::FN_POINT, 32767, -32768);
		add(psr_pkg::FN_POINT, -32768, 32767);
		add(FN_IGNORED, -1, -1);
		add(psr_pkg::FN_END, 123, 45);
		add(psr_pkg::FN_END, -1, -1);
		add(psr_pkg::FN_BREAK, -1, 0);
		add(psr_pkg::FN_BREAK, 32767, 0);
		add(psr_pkg::FN_POINT, 100, -100);
		add(psr_pkg::FN_POINT, 90, -90);
		add(psr_pkg::FN_END, 0, 0);
		send_plan(0);

		run_phase(64, 4096, 100);
		run_phase(0, 65535, 70);
		run_phase(32767, 8, 60);
		wait_idle();
		hold_left = 400;
		run_phase(300, 60, 100);
		calm = 1;
		run_phase($urandom_range(32767), $urandom_range(8, 65535), 80);
		calm = 0;

		wait_idle();
		if (sb.errors == 0) begin
			$display("PASS pen_stroke_resampler");
		end else begin
			$display("FAIL pen_stroke_resampler");
		end
		$finish;
	end
endmodule
